// ===== src/life_automaton_step_assert.svh =====
// Assertion macros for the life_automaton_step block.
// Included by the top level; the macros expect clk and rst_n in scope.
`ifndef LIFE_AUTOMATON_STEP_ASSERT_SVH
`define LIFE_AUTOMATON_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/life_pkg.sv =====
// Shared types and constants for the life_automaton_step block.
// Used by life_ctrl, life_dp and the top level; depends on nothing.
package life_pkg;

  localparam int X_CELLS_DEF = 64;
  localparam int Y_CELLS_DEF = 64;
  localparam int OP_W        = 2;
  localparam int COORD_W     = 6;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Neighbor counts of the generation rule.
  localparam logic [3:0] SURVIVE_LO = 4'd2;
  localparam logic [3:0] SURVIVE_HI = 4'd3;
  localparam logic [3:0] BIRTH_CNT  = 4'd3;

  typedef struct packed {
    logic ld_req;
    logic rd_acc;
    logic rd_last;
    logic rd_first;
    logic rd_next;
    logic wr_clr;
    logic wr_acc;
    logic wr_gen;
    logic ld_prev;
    logic ld_cur;
    logic res_ld;
    logic row_clr;
    logic row_inc;
    logic out_ld;
  } life_cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
    logic row_last;
  } life_sts_t;

endpackage

// ===== src/life_ctrl.sv =====
// Controller state machine of the life_automaton_step block.
// Depends on life_pkg; drives the datapath life_dp through life_cmd_t.
module life_ctrl
  import life_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  life_sts_t sts,
  output life_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_DISPATCH = 11'b00000000100,
    S_ACC_RD   = 11'b00000001000,
    S_ACC_DATA = 11'b00000010000,
    S_G_LAST   = 11'b00000100000,
    S_G_FIRST  = 11'b00001000000,
    S_G_LOAD   = 11'b00010000000,
    S_G_RD     = 11'b00100000000,
    S_G_WR     = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_clr = 1'b1;
        if (sts.row_last) begin
          cmd.row_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.row_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_WRITE, OP_READ: state_nxt = sts.in_range ? S_ACC_RD : S_DONE;
          OP_STEP:           state_nxt = S_G_LAST;
          default:           state_nxt = S_DONE;
        endcase
      end
      S_ACC_RD: begin
        cmd.rd_acc = 1'b1;
        state_nxt  = S_ACC_DATA;
      end
      S_ACC_DATA: begin
        cmd.res_ld = 1'b1;
        cmd.wr_acc = (sts.op == OP_WRITE);
        state_nxt  = S_DONE;
      end
      S_G_LAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_G_FIRST;
      end
      S_G_FIRST: begin
        cmd.rd_first = 1'b1;
        cmd.ld_prev  = 1'b1;
        state_nxt    = S_G_LOAD;
      end
      S_G_LOAD: begin
        cmd.ld_cur  = 1'b1;
        cmd.row_clr = 1'b1;
        state_nxt   = S_G_RD;
      end
      S_G_RD: begin
        // The last row takes its lower neighbor from the saved first row.
        cmd.rd_next = !sts.row_last;
        state_nxt   = S_G_WR;
      end
      S_G_WR: begin
        cmd.wr_gen = 1'b1;
        if (sts.row_last) begin
          cmd.row_clr = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.row_inc = 1'b1;
          state_nxt   = S_G_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/life_dp.sv =====
// Datapath of the life_automaton_step block: the row-wide cell memory,
// the three-row window with the generation rule, and the result registers.
// Depends on life_pkg; controlled by life_ctrl.
module life_dp
  import life_pkg::*;
#(
  parameter int X_CELLS = X_CELLS_DEF,
  parameter int Y_CELLS = Y_CELLS_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [OP_W-1:0]    in_op,
  input  logic [COORD_W-1:0] in_x_index,
  input  logic [COORD_W-1:0] in_y_index,
  input  logic               in_cell_value,
  input  life_cmd_t          cmd,
  output life_sts_t          sts,
  output logic               out_cell_alive,
  output logic               out_step_done
);

  localparam int XW = $clog2(X_CELLS);
  localparam int YW = $clog2(Y_CELLS);

  // One memory row holds all cells that share the first coordinate.
  logic [Y_CELLS-1:0] grid_r [X_CELLS];

  op_t                op_r;
  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;
  logic               val_r;
  logic [XW-1:0]      row_r;
  logic [Y_CELLS-1:0] rdata_r;
  logic [Y_CELLS-1:0] prev_r;
  logic [Y_CELLS-1:0] cur_r;
  logic [Y_CELLS-1:0] first_r;
  logic               res_alive_r;
  logic               out_cell_alive_r;
  logic               out_step_done_r;

  logic [XW-1:0]      x_addr;
  logic [YW-1:0]      y_sel;
  logic               in_range;
  logic               row_last;
  logic               rd_en;
  logic               wr_en;
  logic [XW-1:0]      rd_addr;
  logic [XW-1:0]      wr_addr;
  logic [Y_CELLS-1:0] wr_data;
  logic [Y_CELLS-1:0] acc_row;
  logic [Y_CELLS-1:0] nxt_row;
  logic [Y_CELLS-1:0] new_row;

  assign x_addr   = XW'(x_r);
  assign y_sel    = YW'(y_r);
  assign in_range = (32'(x_r) < X_CELLS) && (32'(y_r) < Y_CELLS);
  assign row_last = (row_r == XW'(X_CELLS - 1));

  assign sts.op       = op_r;
  assign sts.in_range = in_range;
  assign sts.row_last = row_last;

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      op_r  <= op_t'(in_op);
      x_r   <= in_x_index;
      y_r   <= in_y_index;
      val_r <= in_cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (cmd.row_clr) begin
      row_r <= '0;
    end else if (cmd.row_inc) begin
      row_r <= row_r + XW'(1);
    end
  end

  always_comb begin
    if (cmd.rd_acc) begin
      rd_addr = x_addr;
    end else if (cmd.rd_last) begin
      rd_addr = XW'(X_CELLS - 1);
    end else if (cmd.rd_first) begin
      rd_addr = '0;
    end else begin
      rd_addr = row_r + XW'(1);
    end
  end

  always_comb begin
    acc_row        = rdata_r;
    acc_row[y_sel] = val_r;
  end

  assign rd_en   = cmd.rd_acc | cmd.rd_last | cmd.rd_first | cmd.rd_next;
  assign wr_en   = cmd.wr_clr | cmd.wr_acc | cmd.wr_gen;
  assign wr_addr = cmd.wr_acc ? x_addr : row_r;
  assign wr_data = cmd.wr_clr ? '0 : (cmd.wr_acc ? acc_row : new_row);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= grid_r[rd_addr];
    end
  end

  // Old row below the one being written; the last row wraps to the first.
  assign nxt_row = row_last ? first_r : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_prev) begin
      prev_r <= rdata_r;
    end else if (cmd.wr_gen) begin
      prev_r <= cur_r;
    end
    if (cmd.ld_cur) begin
      cur_r   <= rdata_r;
      first_r <= rdata_r;
    end else if (cmd.wr_gen) begin
      cur_r <= nxt_row;
    end
  end

  for (genvar j = 0; j < Y_CELLS; j++) begin : g_col
    localparam int JM = (j == 0) ? Y_CELLS - 1 : j - 1;
    localparam int JP = (j == Y_CELLS - 1) ? 0 : j + 1;
    logic [3:0] cnt;
    assign cnt = 4'(prev_r[JM]) + 4'(prev_r[j]) + 4'(prev_r[JP])
               + 4'(cur_r[JM])  + 4'(cur_r[JP])
               + 4'(nxt_row[JM]) + 4'(nxt_row[j]) + 4'(nxt_row[JP]);
    assign new_row[j] = cur_r[j] ? (cnt == SURVIVE_LO || cnt == SURVIVE_HI)
                                 : (cnt == BIRTH_CNT);
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_alive_r <= rdata_r[y_sel];
    end
    if (cmd.out_ld) begin
      out_cell_alive_r <= (op_r == OP_READ) && in_range && res_alive_r;
      out_step_done_r  <= (op_r == OP_STEP);
    end
  end

  assign out_cell_alive = out_cell_alive_r;
  assign out_step_done  = out_step_done_r;

endmodule

// ===== src/life_automaton_step.sv =====
// Conway's Game of Life on a toroidal X_CELLS by Y_CELLS grid. A request
// writes one cell, reads one cell, or advances the grid by one generation,
// and each request returns exactly one result. The grid lives in a memory
// with one row per first coordinate and a single read and write port; after
// reset a clearing pass writes every row dead before the first request is
// taken. A read or write goes through dispatch, a row read and a data step
// to its result (an off-grid cell or the unused opcode goes from dispatch
// straight to the result); a generation's length is set by the memory port
// fetching one row at a time while a whole row of new cells is computed from
// a three-row window. One request is in work at a time; a result that is not
// taken holds the output register and the finished request waits behind it.
// Depends on life_pkg, life_ctrl, life_dp and life_automaton_step_assert.svh.
`include "life_automaton_step_assert.svh"

module life_automaton_step
  import life_pkg::*;
#(
  parameter int X_CELLS = X_CELLS_DEF,
  parameter int Y_CELLS = Y_CELLS_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  logic [COORD_W-1:0] in_x_index,
  input  logic [COORD_W-1:0] in_y_index,
  input  logic               in_cell_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_cell_alive,
  output logic               out_step_done
);

  life_cmd_t  cmd;
  life_sts_t  sts;
  logic [2:0] wr_vec;

  life_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  life_dp #(
    .X_CELLS(X_CELLS),
    .Y_CELLS(Y_CELLS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_op),
    .in_x_index    (in_x_index),
    .in_y_index    (in_y_index),
    .in_cell_value (in_cell_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_cell_alive(out_cell_alive),
    .out_step_done (out_step_done)
  );

  assign wr_vec = {cmd.wr_clr, cmd.wr_acc, cmd.wr_gen};

  // Only one source may drive the memory write port in a cycle.
  `LAS_ASSERT_SAME(a_one_writer, 1'b1, $onehot0(wr_vec), "two memory writers at once")
  // A request in work blocks the next one.
  `LAS_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while busy")
  // A result is either a generation done or a cell read, never both.
  `LAS_ASSERT_SAME(a_result_kind, out_valid && out_step_done, !out_cell_alive, "mixed result")
  // A result is only loaded into a free output register.
  `LAS_ASSERT_SAME(a_out_free, cmd.out_ld, !out_valid || out_ready, "result overwritten")

endmodule

// ===== tb/life_step_checker.sv =====
// Checker for life_automaton_step: watches the request and result channels,
// keeps its own copy of the toroidal grid and compares every result in order.
// Depends on life_pkg for the opcode type and the port widths.
module life_step_checker
  import life_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  logic [COORD_W-1:0] in_x_index,
  input  logic [COORD_W-1:0] in_y_index,
  input  logic               in_cell_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_cell_alive,
  input  logic               out_step_done,
  output int                 mismatch_count,
  output int                 pending_count
);

  localparam int GRID_X   = X_CELLS_DEF;
  localparam int GRID_Y   = Y_CELLS_DEF;
  localparam int STAY_MIN = 2;
  localparam int STAY_MAX = 3;
  localparam int BORN_AT  = 3;

  typedef struct packed {
    logic alive;
    logic done;
  } life_result_t;

  bit           alive_map [GRID_X][GRID_Y];
  bit           next_map  [GRID_X][GRID_Y];
  life_result_t expected_results [$];
  int           err_tally = 0;
  int           result_no = 0;

  assign mismatch_count = err_tally;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_tally++;
  endtask

  function automatic int live_neighbors(input int cx, input int cy);
    int total;
    total = 0;
    for (int dx = -1; dx <= 1; dx++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        if (dx != 0 || dy != 0)
          total += alive_map[(cx + dx + GRID_X) % GRID_X][(cy + dy + GRID_Y) % GRID_Y];
      end
    end
    return total;
  endfunction

  // Every cell is computed from the old grid before any of them is replaced.
  function automatic void evolve_grid();
    int n;
    for (int cx = 0; cx < GRID_X; cx++) begin
      for (int cy = 0; cy < GRID_Y; cy++) begin
        n = live_neighbors(cx, cy);
        if (alive_map[cx][cy])
          next_map[cx][cy] = (n == STAY_MIN || n == STAY_MAX);
        else
          next_map[cx][cy] = (n == BORN_AT);
      end
    end
    alive_map = next_map;
  endfunction

  function automatic life_result_t predict_request(input op_t op,
                                                   input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic v);
    life_result_t res;
    res = '0;
    case (op)
      OP_WRITE: begin
        if (x < GRID_X && y < GRID_Y)
          alive_map[x][y] = v;
      end
      OP_STEP: begin
        evolve_grid();
        res.done = 1'b1;
      end
      OP_READ: begin
        if (x < GRID_X && y < GRID_Y)
          res.alive = alive_map[x][y];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch_channels
    life_result_t want;
    if (!rst_n) begin
      alive_map = '{default: 1'b0};
      expected_results.delete();
    end else begin
      // Results are checked before new requests are predicted, so a result
      // leaving on the same edge always meets its own expectation.
      if (out_valid && out_ready) begin
        result_no++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request waiting",
                                    result_no));
        end else begin
          want = expected_results.pop_front();
          if (out_cell_alive !== want.alive)
            report_mismatch($sformatf("result %0d cell_alive %b, wanted %b",
                                      result_no, out_cell_alive, want.alive));
          if (out_step_done !== want.done)
            report_mismatch($sformatf("result %0d step_done %b, wanted %b",
                                      result_no, out_step_done, want.done));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_request(op_t'(in_op), in_x_index,
                                                   in_y_index, in_cell_value));
    end
    pending_count <= expected_results.size();
  end

endmodule

// ===== tb/tb_life_automaton_step.sv =====
// Testbench top for life_automaton_step: drives requests in bursts, stalls the
// result side, and gives the verdict from the checker's mismatch and pending counts.
// Depends on life_pkg, life_automaton_step and life_step_checker.
module tb_life_automaton_step;
  import life_pkg::*;

  localparam int RANDOM_REQS = 115;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 150;
  localparam int DRAIN_LIMIT = 50000;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_op         = '0;
  logic [COORD_W-1:0] in_x_index    = '0;
  logic [COORD_W-1:0] in_y_index    = '0;
  logic               in_cell_value = 1'b0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic               out_cell_alive;
  logic               out_step_done;

  int mismatch_count;
  int pending_count;

  int sent_reqs  = 0;
  int burst_left = 0;
  bit no_gaps    = 1'b0;
  bit hold_req   = 1'b0;
  int hold_left  = 0;
  int seg_left   = 0;
  int seg_mode   = 0;

  life_automaton_step uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_x_index    (in_x_index),
    .in_y_index    (in_y_index),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_alive(out_cell_alive),
    .out_step_done (out_step_done)
  );

  life_step_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_x_index    (in_x_index),
    .in_y_index    (in_y_index),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_alive(out_cell_alive),
    .out_step_done (out_step_done),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding", pending_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The result side runs in segments of free flow, random stalls and heavy
  // stalls; a long hold-off is inserted whenever the stimulus asks for one.
  always @(posedge clk) begin : result_stall
    logic rdy;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      rdy = 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(8, 64);
      end
      seg_left--;
      case (seg_mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
    end
    out_ready <= rdy;
  end

  // Called right after a rising edge; returns at the edge that accepts the
  // request, leaving valid high, or after a gap with valid low at a burst end.
  task automatic issue_req(input op_t op, input int x, input int y, input logic v);
    int gap;
    in_valid      <= 1'b1;
    in_op         <= op;
    in_x_index    <= x[COORD_W-1:0];
    in_y_index    <= y[COORD_W-1:0];
    in_cell_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_reqs++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_wait(input int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic int wrap_coord(input int base, input int offset);
    return (base + offset + 64) % 64;
  endfunction

  initial begin : stimulus
    int cx;
    int cy;
    int episode;
    int random_start;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Blinker lying across the x wrap, plus extremes and ignored fields.
    issue_req(OP_WRITE, 0, 0, 1'b1);
    issue_req(OP_WRITE, 63, 0, 1'b1);
    issue_req(OP_WRITE, 1, 0, 1'b1);
    issue_req(OP_WRITE, 32, 32, 1'b1);
    issue_req(OP_READ, 32, 32, 1'b0);
    issue_req(OP_WRITE, 32, 32, 1'b0);
    issue_req(OP_READ, 32, 32, 1'b1);
    issue_req(OP_READ, 63, 0, 1'b0);
    issue_req(OP_NONE, 63, 63, 1'b1);
    issue_req(OP_READ, 63, 63, 1'b0);
    issue_req(OP_STEP, 63, 63, 1'b1);
    issue_req(OP_READ, 0, 63, 1'b0);
    issue_req(OP_READ, 0, 1, 1'b0);
    issue_req(OP_READ, 0, 0, 1'b0);
    issue_req(OP_READ, 63, 0, 1'b0);
    issue_req(OP_STEP, 0, 0, 1'b0);
    issue_req(OP_READ, 63, 0, 1'b0);
    issue_req(OP_READ, 0, 63, 1'b0);
    issue_req(OP_WRITE, 63, 63, 1'b1);
    issue_req(OP_READ, 63, 63, 1'b0);
    issue_req(OP_WRITE, 42, 21, 1'b1);
    issue_req(OP_READ, 42, 21, 1'b0);
    issue_req(OP_READ, 21, 42, 1'b1);

    // Each episode seeds a small patch, lets it evolve and probes it.
    episode = 0;
    random_start = sent_reqs;
    while (sent_reqs - random_start < RANDOM_REQS) begin
      if (episode == 2) begin
        hold_req = 1'b1;
        no_gaps  = 1'b1;
      end
      if (episode == 3)
        no_gaps = 1'b0;
      if (episode == 5)
        drain_wait(DRAIN_LIMIT);

      if ($urandom_range(0, 1) == 0) begin
        cx = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(61, 63);
        cy = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(61, 63);
      end else begin
        cx = $urandom_range(0, 63);
        cy = $urandom_range(0, 63);
      end

      repeat ($urandom_range(4, 8))
        issue_req(OP_WRITE, wrap_coord(cx, $urandom_range(0, 4) - 2),
                  wrap_coord(cy, $urandom_range(0, 4) - 2),
                  $urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        issue_req(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1))
          issue_req(OP_READ, wrap_coord(cx, $urandom_range(0, 4) - 2),
                    wrap_coord(cy, $urandom_range(0, 4) - 2),
                    1'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(3, 6))
        issue_req(OP_READ, wrap_coord(cx, $urandom_range(0, 4) - 2),
                  wrap_coord(cy, $urandom_range(0, 4) - 2),
                  1'($urandom_range(0, 1)));

      // Noise: unused opcode and stray accesses anywhere on the grid.
      if ($urandom_range(0, 2) == 0)
        issue_req(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0)
        issue_req(op_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                  $urandom_range(0, 63), 1'($urandom_range(0, 1)));
      episode++;
    end

    drain_wait(DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_count != 0)
      $display("%0d results never arrived", pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
